### rtl/core/nucleation_spacing_filter_macros.svh
`ifndef NUCLEATION_SPACING_FILTER_MACROS_SVH
`define NUCLEATION_SPACING_FILTER_MACROS_SVH

// Same-cycle implication, reset masks the check.
`define NSF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nucleation_spacing_filter: check failed");

// Next-cycle implication, reset masks the check.
`define NSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nucleation_spacing_filter: check failed");

`endif

### rtl/core/nsf_pkg.sv
package nsf_pkg;

    localparam int SQ_W       = 52;
    localparam int BASE_W     = 20;
    localparam int INDEX_W    = 21;
    localparam int DIM_W      = 2;
    localparam int CFG_DATA_W = 52;
    localparam int CFG_IDX_W  = 2;

    localparam logic [DIM_W-1:0] DIM_PLANAR = 2'd2;
    localparam logic [DIM_W-1:0] DIM_RESET  = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_SEP        = 2'd0,
        CFG_SAME_PHASE_SEP = 2'd1,
        CFG_INDEX_BASE     = 2'd2,
        CFG_DIMENSIONS     = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        VERDICT_KEPT     = 2'd0,
        VERDICT_CONFLICT = 2'd1,
        VERDICT_FULL     = 2'd2
    } verdict_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } ctrl_state_t;

    // controller to distance pipeline
    typedef struct packed {
        logic issue;
        logic clear;
    } dp_ctl_t;

    // distance pipeline to controller
    typedef struct packed {
        logic busy;
        logic conflict;
    } dp_stat_t;

endpackage

### rtl/core/nucleation_spacing_filter.sv
// Minimum-spacing filter for candidate nucleus centers.
// Configuration: write wr_data to register wr_index while wr_en is high; registers are
// min_sep_sq, min_same_phase_sep_sq, index_base and dimensions, to be written only while
// idle by the user (the block does not enforce it). Input: a candidate transaction is
// taken on a clock edge with start high and busy low. start_list clears the list before
// that candidate is checked. Each candidate is checked against every earlier candidate
// of the list, one stored entry per cycle read from the candidate memory, through a
// three-stage distance pipeline. With N candidates already in the list, the N stored
// entries are read in turn through the single read port of the candidate memory, the
// distance pipeline drains, and done then pulses; when the store is full, both are
// skipped. A new candidate is not taken while the last one is still being checked.
// Output: done is high for one cycle with verdict and assigned_index; the receiver takes
// it at the edge that ends that cycle and cannot stall it. busy drops in that same cycle,
// so the next candidate may be started while the result is shown.
// Reset: clears both counts, the control state and the registers to their defaults;
// the candidate memory needs no clearing since only entries of the current list are read.
`include "nucleation_spacing_filter_macros.svh"

module nucleation_spacing_filter #(
    parameter int MAX_CANDIDATES = 256,
    parameter int COORD_BITS     = 24,
    parameter int PHASE_BITS     = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [nsf_pkg::CFG_IDX_W-1:0]       wr_index,
    input  logic [nsf_pkg::CFG_DATA_W-1:0]      wr_data,
    input  logic                                start,
    output logic                                busy,
    input  logic                                start_list,
    input  logic signed [COORD_BITS-1:0]        center_x,
    input  logic signed [COORD_BITS-1:0]        center_y,
    input  logic signed [COORD_BITS-1:0]        center_z,
    input  logic [PHASE_BITS-1:0]               phase_index,
    output logic                                done,
    output logic [1:0]                          verdict,
    output logic [nsf_pkg::INDEX_W-1:0]         assigned_index
);

    import nsf_pkg::*;

    localparam int ADDR_W = $clog2(MAX_CANDIDATES);
    localparam int EW     = 3 * COORD_BITS + PHASE_BITS;

    logic [SQ_W-1:0]   min_sep_reg;
    logic [SQ_W-1:0]   same_sep_reg;
    logic [BASE_W-1:0] base_reg;
    logic [DIM_W-1:0]  dims_reg;

    logic signed [COORD_BITS-1:0] cand_x_reg;
    logic signed [COORD_BITS-1:0] cand_y_reg;
    logic signed [COORD_BITS-1:0] cand_z_reg;
    logic [PHASE_BITS-1:0]        cand_phase_reg;

    logic              accept;
    dp_ctl_t           dp_ctl;
    dp_stat_t          dp_stat;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [EW-1:0]     mem_rd_data;
    verdict_t          verdict_int;

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_sep_reg  <= '0;
            same_sep_reg <= '0;
            base_reg     <= '0;
            dims_reg     <= DIM_RESET;
        end
        else if (wr_en)
        begin
            case (cfg_reg_t'(wr_index))
                CFG_MIN_SEP:        min_sep_reg  <= wr_data[SQ_W-1:0];
                CFG_SAME_PHASE_SEP: same_sep_reg <= wr_data[SQ_W-1:0];
                CFG_INDEX_BASE:     base_reg     <= wr_data[BASE_W-1:0];
                CFG_DIMENSIONS:     dims_reg     <= wr_data[DIM_W-1:0];
                default:            dims_reg     <= dims_reg;
            endcase
        end
    end

    // hold the candidate for the whole scan
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cand_x_reg     <= center_x;
            cand_y_reg     <= center_y;
            cand_z_reg     <= center_z;
            cand_phase_reg <= phase_index;
        end
    end

    nsf_ctrl #(
        .MAX_CANDIDATES (MAX_CANDIDATES)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .start_list     (start_list),
        .index_base     (base_reg),
        .dp_stat        (dp_stat),
        .dp_ctl         (dp_ctl),
        .busy           (busy),
        .rd_addr        (mem_rd_addr),
        .wr_en          (mem_wr_en),
        .wr_addr        (mem_wr_addr),
        .done           (done),
        .verdict        (verdict_int),
        .assigned_index (assigned_index)
    );

    nsf_cand_mem #(
        .DEPTH (MAX_CANDIDATES),
        .WIDTH (EW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data ({cand_x_reg, cand_y_reg, cand_z_reg, cand_phase_reg}),
        .rd_en   (dp_ctl.issue),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    nsf_dist_pipe #(
        .COORD_BITS (COORD_BITS),
        .PHASE_BITS (PHASE_BITS)
    ) u_dist (
        .clk         (clk),
        .rst_n       (rst_n),
        .dp_ctl      (dp_ctl),
        .rd_data     (mem_rd_data),
        .cand_x      (cand_x_reg),
        .cand_y      (cand_y_reg),
        .cand_z      (cand_z_reg),
        .cand_phase  (cand_phase_reg),
        .use_z       (dims_reg != DIM_PLANAR),
        .min_sep_sq  (min_sep_reg),
        .same_sep_sq (same_sep_reg),
        .dp_stat     (dp_stat)
    );

    assign verdict = verdict_int;

    `NSF_ASSERT_NEXT(a_accept_goes_busy, clk, rst_n, start && !busy, busy)
    `NSF_ASSERT_NOW(a_done_ends_work, clk, rst_n, done, !busy && $past(busy))
    `NSF_ASSERT_NOW(a_reject_no_index, clk, rst_n, done && (verdict_int != VERDICT_KEPT), assigned_index == '0)

endmodule

### rtl/core/nsf_cand_mem.sv
module nsf_cand_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 80
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/core/nsf_dist_pipe.sv
module nsf_dist_pipe #(
    parameter int COORD_BITS = 24,
    parameter int PHASE_BITS = 8
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  nsf_pkg::dp_ctl_t                         dp_ctl,
    input  logic [3*COORD_BITS+PHASE_BITS-1:0]       rd_data,
    input  logic signed [COORD_BITS-1:0]             cand_x,
    input  logic signed [COORD_BITS-1:0]             cand_y,
    input  logic signed [COORD_BITS-1:0]             cand_z,
    input  logic [PHASE_BITS-1:0]                    cand_phase,
    input  logic                                     use_z,
    input  logic [nsf_pkg::SQ_W-1:0]                 min_sep_sq,
    input  logic [nsf_pkg::SQ_W-1:0]                 same_sep_sq,
    output nsf_pkg::dp_stat_t                        dp_stat
);

    import nsf_pkg::*;

    localparam int MW = COORD_BITS + 1;
    localparam int QW = 2 * MW;
    localparam int SW = QW + 2;
    localparam int CW = (SW > SQ_W) ? SW : SQ_W;

    logic signed [COORD_BITS-1:0] st_x;
    logic signed [COORD_BITS-1:0] st_y;
    logic signed [COORD_BITS-1:0] st_z;
    logic [PHASE_BITS-1:0]        st_phase;

    logic signed [MW-1:0] dx;
    logic signed [MW-1:0] dy;
    logic signed [MW-1:0] dz;

    logic          v_rd_reg;
    logic          v1_reg;
    logic          v2_reg;
    logic          conflict_reg;
    logic [MW-1:0] mx_reg;
    logic [MW-1:0] my_reg;
    logic [MW-1:0] mz_reg;
    logic          peq1_reg;
    logic [QW-1:0] sqx_reg;
    logic [QW-1:0] sqy_reg;
    logic [QW-1:0] sqz_reg;
    logic          peq2_reg;

    logic [SW-1:0] sum_sq;
    logic          hit;

    assign st_x     = rd_data[3*COORD_BITS+PHASE_BITS-1 -: COORD_BITS];
    assign st_y     = rd_data[2*COORD_BITS+PHASE_BITS-1 -: COORD_BITS];
    assign st_z     = rd_data[COORD_BITS+PHASE_BITS-1 -: COORD_BITS];
    assign st_phase = rd_data[PHASE_BITS-1:0];

    always_comb
    begin
        dx = MW'(cand_x) - MW'(st_x);
        dy = MW'(cand_y) - MW'(st_y);
        dz = MW'(cand_z) - MW'(st_z);
    end

    // squares of up to three terms never reach the top of SW, so no saturation
    always_comb
    begin
        sum_sq = SW'(sqx_reg) + SW'(sqy_reg) + SW'(sqz_reg);
        hit    = (CW'(sum_sq) < CW'(min_sep_sq)) ||
                 (peq2_reg && (CW'(sum_sq) < CW'(same_sep_sq)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_rd_reg     <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            conflict_reg <= 1'b0;
        end
        else
        begin
            v_rd_reg <= dp_ctl.issue;
            v1_reg   <= v_rd_reg;
            v2_reg   <= v1_reg;
            if (dp_ctl.clear)
            begin
                conflict_reg <= 1'b0;
            end
            else if (v2_reg && hit)
            begin
                conflict_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg   <= dx[MW-1] ? $unsigned(-dx) : $unsigned(dx);
        my_reg   <= dy[MW-1] ? $unsigned(-dy) : $unsigned(dy);
        mz_reg   <= use_z ? (dz[MW-1] ? $unsigned(-dz) : $unsigned(dz)) : '0;
        peq1_reg <= (st_phase == cand_phase);
        sqx_reg  <= mx_reg * mx_reg;
        sqy_reg  <= my_reg * my_reg;
        sqz_reg  <= mz_reg * mz_reg;
        peq2_reg <= peq1_reg;
    end

    assign dp_stat.busy     = v_rd_reg || v1_reg || v2_reg;
    assign dp_stat.conflict = conflict_reg;

endmodule

### rtl/core/nsf_ctrl.sv
module nsf_ctrl #(
    parameter int MAX_CANDIDATES = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 start_list,
    input  logic [nsf_pkg::BASE_W-1:0]           index_base,
    input  nsf_pkg::dp_stat_t                    dp_stat,
    output nsf_pkg::dp_ctl_t                     dp_ctl,
    output logic                                 busy,
    output logic [$clog2(MAX_CANDIDATES)-1:0]    rd_addr,
    output logic                                 wr_en,
    output logic [$clog2(MAX_CANDIDATES)-1:0]    wr_addr,
    output logic                                 done,
    output nsf_pkg::verdict_t                    verdict,
    output logic [nsf_pkg::INDEX_W-1:0]          assigned_index
);

    import nsf_pkg::*;

    localparam int ADDR_W = $clog2(MAX_CANDIDATES);
    localparam int CNT_W  = $clog2(MAX_CANDIDATES + 1);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    logic [CNT_W-1:0]   attempt_reg;
    logic [CNT_W-1:0]   kept_reg;
    logic [CNT_W-1:0]   ptr_reg;
    logic               done_reg;
    verdict_t           verdict_reg;
    logic [INDEX_W-1:0] index_reg;

    logic accept;
    logic full;
    logic scan_more;
    logic finish;

    assign accept    = start && (state_reg == ST_IDLE);
    assign full      = (attempt_reg == CNT_W'(MAX_CANDIDATES));
    assign scan_more = (ptr_reg < attempt_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (full)
                begin
                    state_next = ST_FINISH;
                end
                else if (!scan_more)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!dp_stat.busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy         = 1'b1;
        dp_ctl.issue = 1'b0;
        dp_ctl.clear = accept;
        wr_en        = 1'b0;
        finish       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_SCAN:
            begin
                dp_ctl.issue = !full && scan_more;
            end
            ST_DRAIN:
            begin
                busy = 1'b1;
            end
            ST_FINISH:
            begin
                wr_en  = !full;
                finish = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    assign rd_addr = ptr_reg[ADDR_W-1:0];
    assign wr_addr = attempt_reg[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            attempt_reg <= '0;
            kept_reg    <= '0;
            ptr_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= finish;
            if (accept)
            begin
                ptr_reg <= '0;
                if (start_list)
                begin
                    attempt_reg <= '0;
                    kept_reg    <= '0;
                end
            end
            else if (dp_ctl.issue)
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            else if (finish && !full)
            begin
                attempt_reg <= attempt_reg + 1'b1;
                if (!dp_stat.conflict)
                begin
                    kept_reg <= kept_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            if (full)
            begin
                verdict_reg <= VERDICT_FULL;
                index_reg   <= '0;
            end
            else if (dp_stat.conflict)
            begin
                verdict_reg <= VERDICT_CONFLICT;
                index_reg   <= '0;
            end
            else
            begin
                verdict_reg <= VERDICT_KEPT;
                index_reg   <= INDEX_W'(index_base) + INDEX_W'(kept_reg);
            end
        end
    end

    assign done           = done_reg;
    assign verdict        = verdict_reg;
    assign assigned_index = index_reg;

endmodule
